@@ hw/rtl/v3ar_pkg.sv @@
// ---------------------------------------------------------------------------
// v3ar_pkg - shared types and constants of the principal axis rotator
// Fixed-point widths, angle constants in Q2.30, the arctangent table of
// the CORDIC row, and the request record that travels down the pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package v3ar_pkg;

	// axis codes
	localparam logic [1:0] AXIS_X    = 2'd0;
	localparam logic [1:0] AXIS_Y    = 2'd1;
	localparam logic [1:0] AXIS_Z    = 2'd2;
	localparam logic [1:0] AXIS_NONE = 2'd3;

	// widths
	localparam int VEC_W = 32;   // Q16.16 components
	localparam int ANG_W = 35;   // input angle times four, Q2.30, before reduction
	localparam int Z_W   = 33;   // reduced angle and CORDIC residual angle
	localparam int X_W   = 34;   // CORDIC x and y
	localparam int TRIG_W = 32;  // final cosine and sine, Q2.30
	localparam int PROD_W = 64;
	localparam int SUM_W  = 65;

	// angle constants, Q2.30
	localparam logic signed [ANG_W-1:0] PI_WIDE     = 35'sd3373259426;
	localparam logic signed [ANG_W-1:0] NEG_PI_WIDE = -35'sd3373259426;
	localparam logic signed [ANG_W-1:0] TWO_PI_WIDE = 35'sd6746518852;
	localparam logic signed [Z_W-1:0]   PI_Q30       = 33'sd3373259426;
	localparam logic signed [Z_W-1:0]   HALF_PI_Q30  = 33'sd1686629713;
	localparam logic signed [Z_W-1:0]   NEG_HALF_PI_Q30 = -33'sd1686629713;

	// limiting CORDIC gain 1/K, Q2.30
	localparam logic signed [X_W-1:0] CORDIC_GAIN = 34'sd652032874;

	// atan(2^-i), Q2.30, truncated
	localparam logic [31:0] ATAN_Q30 [32] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
		32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
		32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
		32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
		32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
	};

	// request record carried alongside the angle datapath
	typedef struct packed {
		logic [1:0]              axis;
		logic signed [VEC_W-1:0] vec_x;
		logic signed [VEC_W-1:0] vec_y;
		logic signed [VEC_W-1:0] vec_z;
		logic                    neg;     // cos and sin must be negated
	} item_t;

	// CORDIC working set handed from cell to cell
	typedef struct packed {
		logic signed [X_W-1:0] x;
		logic signed [X_W-1:0] y;
		logic signed [Z_W-1:0] z;
	} cordic_t;

endpackage

`default_nettype wire

@@ hw/rtl/v3ar_angle_fold.sv @@
// ---------------------------------------------------------------------------
// v3ar_angle_fold - angle reduction front end
// Stage 1 reduces the angle into [-pi, pi]; stage 2 folds it into
// [-pi/2, pi/2], flags the fold, and loads the CORDIC start values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module v3ar_angle_fold (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic signed [31:0]            angle_rad,
	input  wire v3ar_pkg::item_t               in_item,
	output logic                               out_valid,
	output v3ar_pkg::cordic_t                  out_vec,
	output v3ar_pkg::item_t                    out_item
);
	import v3ar_pkg::*;

	logic signed [ANG_W-1:0] ang_wide;
	logic signed [ANG_W-1:0] ang_red;
	logic                    valid_s1;
	logic signed [Z_W-1:0]   red_s1;
	item_t                   item_s1;
	logic signed [Z_W-1:0]   fold_ang;
	logic                    fold_neg;
	cordic_t                 vec_fold;
	item_t                   item_fold;
	logic                    valid_s2;
	cordic_t                 vec_s2;
	item_t                   item_s2;

	// Q4.28 to Q2.30, one wrap by two pi covers the whole input range
	always_comb begin
		ang_wide = {angle_rad[31], angle_rad, 2'b00};
		ang_red  = ang_wide;
		if (ang_wide > PI_WIDE) begin
			ang_red = ang_wide - TWO_PI_WIDE;
		end else if (ang_wide < NEG_PI_WIDE) begin
			ang_red = ang_wide + TWO_PI_WIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s1  <= ang_red[Z_W-1:0];
			item_s1 <= in_item;
		end
	end

	// fold into the right half plane, build the CORDIC start values
	always_comb begin
		fold_ang = red_s1;
		fold_neg = 1'b0;
		if (red_s1 > HALF_PI_Q30) begin
			fold_ang = red_s1 - PI_Q30;
			fold_neg = 1'b1;
		end else if (red_s1 < NEG_HALF_PI_Q30) begin
			fold_ang = red_s1 + PI_Q30;
			fold_neg = 1'b1;
		end
		vec_fold.x    = CORDIC_GAIN;
		vec_fold.y    = '0;
		vec_fold.z    = fold_ang;
		item_fold     = item_s1;
		item_fold.neg = fold_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s2  <= vec_fold;
			item_s2 <= item_fold;
		end
	end

	assign out_valid = valid_s2;
	assign out_vec   = vec_s2;
	assign out_item  = item_s2;

endmodule

`default_nettype wire

@@ hw/rtl/v3ar_cordic_cell.sv @@
// ---------------------------------------------------------------------------
// v3ar_cordic_cell - one CORDIC rotation step
// Rotates (x, y) by +-atan(2^-STAGE) toward a zero residual angle and
// passes the request record on to the next cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module v3ar_cordic_cell #(
	parameter int STAGE = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire v3ar_pkg::cordic_t in_vec,
	input  wire v3ar_pkg::item_t   in_item,
	output logic               out_valid,
	output v3ar_pkg::cordic_t  out_vec,
	output v3ar_pkg::item_t    out_item
);
	import v3ar_pkg::*;

	logic signed [X_W-1:0] x_sh;
	logic signed [X_W-1:0] y_sh;
	logic signed [Z_W-1:0] atan_val;
	cordic_t               nxt;
	logic                  valid_q;
	cordic_t               vec_q;
	item_t                 item_q;

	// micro-rotation, direction from the sign of the residual angle
	always_comb begin
		x_sh     = in_vec.x >>> STAGE;
		y_sh     = in_vec.y >>> STAGE;
		atan_val = signed'({{(Z_W-32){1'b0}}, ATAN_Q30[STAGE]});
		if (!in_vec.z[Z_W-1]) begin
			nxt.x = in_vec.x - y_sh;
			nxt.y = in_vec.y + x_sh;
			nxt.z = in_vec.z - atan_val;
		end else begin
			nxt.x = in_vec.x + y_sh;
			nxt.y = in_vec.y - x_sh;
			nxt.z = in_vec.z + atan_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_q  <= nxt;
			item_q <= in_item;
		end
	end

	assign out_valid = valid_q;
	assign out_vec   = vec_q;
	assign out_item  = item_q;

endmodule

`default_nettype wire

@@ hw/rtl/v3ar_rotate_out.sv @@
// ---------------------------------------------------------------------------
// v3ar_rotate_out - pair rotation back end
// Stage 1 picks the off-axis pair and signs cos/sin, stage 2 forms the
// four products, stage 3 rounds, saturates and holds the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module v3ar_rotate_out (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire v3ar_pkg::cordic_t   in_vec,
	input  wire v3ar_pkg::item_t     in_item,
	output logic                     out_valid,
	output logic signed [31:0]       out_x,
	output logic signed [31:0]       out_y,
	output logic signed [31:0]       out_z
);
	import v3ar_pkg::*;

	logic signed [X_W-1:0]    cos_full;
	logic signed [X_W-1:0]    sin_full;
	logic signed [VEC_W-1:0]  a_sel;
	logic signed [VEC_W-1:0]  b_sel;

	logic                     valid_s1;
	logic signed [TRIG_W-1:0] cos_s1;
	logic signed [TRIG_W-1:0] sin_s1;
	logic signed [VEC_W-1:0]  a_s1;
	logic signed [VEC_W-1:0]  b_s1;
	item_t                    item_s1;

	logic                     valid_s2;
	logic signed [PROD_W-1:0] ac_s2;
	logic signed [PROD_W-1:0] bs_s2;
	logic signed [PROD_W-1:0] as_s2;
	logic signed [PROD_W-1:0] bc_s2;
	item_t                    item_s2;

	logic signed [VEC_W-1:0]  p_res;
	logic signed [VEC_W-1:0]  q_res;
	logic signed [VEC_W-1:0]  x_nxt;
	logic signed [VEC_W-1:0]  y_nxt;
	logic signed [VEC_W-1:0]  z_nxt;

	logic                     valid_q;
	logic signed [VEC_W-1:0]  x_q;
	logic signed [VEC_W-1:0]  y_q;
	logic signed [VEC_W-1:0]  z_q;

	// round half up by 2^-30, then clamp to 32 bits
	function automatic logic signed [VEC_W-1:0] round_sat(
		input logic signed [SUM_W-1:0] acc
	);
		logic signed [SUM_W-1:0] r;
		r = (acc + SUM_W'(64'sd536870912)) >>> 30;
		if (r > SUM_W'(64'sd2147483647)) begin
			return 32'sh7FFFFFFF;
		end else if (r < SUM_W'(-64'sd2147483648)) begin
			return 32'sh80000000;
		end
		return r[VEC_W-1:0];
	endfunction

	// stage 1: operand pick and sign of the fold
	always_comb begin
		cos_full = in_item.neg ? -in_vec.x : in_vec.x;
		sin_full = in_item.neg ? -in_vec.y : in_vec.y;
		unique case (in_item.axis)
			AXIS_X: begin
				a_sel = in_item.vec_y;
				b_sel = in_item.vec_z;
			end
			AXIS_Y: begin
				a_sel = in_item.vec_x;
				b_sel = in_item.vec_z;
			end
			default: begin
				a_sel = in_item.vec_x;
				b_sel = in_item.vec_y;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s1  <= cos_full[TRIG_W-1:0];
			sin_s1  <= sin_full[TRIG_W-1:0];
			a_s1    <= a_sel;
			b_s1    <= b_sel;
			item_s1 <= in_item;
		end
	end

	// stage 2: products
	always_ff @(posedge clk) begin
		if (en) begin
			ac_s2   <= PROD_W'(a_s1) * PROD_W'(cos_s1);
			bs_s2   <= PROD_W'(b_s1) * PROD_W'(sin_s1);
			as_s2   <= PROD_W'(a_s1) * PROD_W'(sin_s1);
			bc_s2   <= PROD_W'(b_s1) * PROD_W'(cos_s1);
			item_s2 <= item_s1;
		end
	end

	// stage 3: sums, rounding, placement of the pair
	always_comb begin
		p_res = round_sat(SUM_W'(ac_s2) - SUM_W'(bs_s2));
		q_res = round_sat(SUM_W'(as_s2) + SUM_W'(bc_s2));
		x_nxt = item_s2.vec_x;
		y_nxt = item_s2.vec_y;
		z_nxt = item_s2.vec_z;
		unique case (item_s2.axis)
			AXIS_X: begin
				y_nxt = p_res;
				z_nxt = q_res;
			end
			AXIS_Y: begin
				x_nxt = p_res;
				z_nxt = q_res;
			end
			AXIS_Z: begin
				x_nxt = p_res;
				y_nxt = q_res;
			end
			default: begin
				// unused axis code: vector passes through
				x_nxt = item_s2.vec_x;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= x_nxt;
			y_q <= y_nxt;
			z_q <= z_nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_z     = z_q;

endmodule

`default_nettype wire

@@ hw/rtl/vec3_axis_rotator_unit.sv @@
// ---------------------------------------------------------------------------
// vec3_axis_rotator_unit - rotation of a Q16.16 vector about x, y or z
// Angle reduction, a row of CORDIC cells for cos/sin, then a pair
// rotation with rounding and saturation.
// ---------------------------------------------------------------------------
// Throughput: one request per cycle; every register stage advances together
// whenever the output register is empty or being read, one cell per CORDIC
// step of the row.
// Reset: arst_n clears all valid flags; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module vec3_axis_rotator_unit #(
	parameter int ROT_STAGES = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         axis,
	input  wire logic signed [31:0] vec_x,
	input  wire logic signed [31:0] vec_y,
	input  wire logic signed [31:0] vec_z,
	input  wire logic signed [31:0] angle_rad,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      out_x,
	output logic signed [31:0]      out_y,
	output logic signed [31:0]      out_z
);
	import v3ar_pkg::*;

	logic    en;
	item_t   in_item;
	logic    chain_valid [ROT_STAGES+1];
	cordic_t chain_vec   [ROT_STAGES+1];
	item_t   chain_item  [ROT_STAGES+1];

	// global advance: move when the result slot frees up
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_comb begin
		in_item.axis  = axis;
		in_item.vec_x = vec_x;
		in_item.vec_y = vec_y;
		in_item.vec_z = vec_z;
		in_item.neg   = 1'b0;
	end

	v3ar_angle_fold u_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.angle_rad (angle_rad),
		.in_item   (in_item),
		.out_valid (chain_valid[0]),
		.out_vec   (chain_vec[0]),
		.out_item  (chain_item[0])
	);

	// CORDIC row
	for (genvar g = 0; g < ROT_STAGES; g++) begin : g_cell
		v3ar_cordic_cell #(
			.STAGE (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_valid[g]),
			.in_vec    (chain_vec[g]),
			.in_item   (chain_item[g]),
			.out_valid (chain_valid[g+1]),
			.out_vec   (chain_vec[g+1]),
			.out_item  (chain_item[g+1])
		);
	end

	v3ar_rotate_out u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (chain_valid[ROT_STAGES]),
		.in_vec    (chain_vec[ROT_STAGES]),
		.in_item   (chain_item[ROT_STAGES]),
		.out_valid (out_valid),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z)
	);

	// folded angle entering the row lies in [-pi/2, pi/2]
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[0] |-> (chain_vec[0].z <= HALF_PI_Q30 &&
			chain_vec[0].z >= NEG_HALF_PI_Q30))
		else $error("folded angle out of range");

	// a stalled pipeline keeps the request at the end of the row
	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && chain_valid[ROT_STAGES]) |=>
			(chain_valid[ROT_STAGES] && $stable(chain_vec[ROT_STAGES])))
		else $error("CORDIC row moved during stall");

	// the CORDIC start values always load the gain with zero sine
	a_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[0] |-> (chain_vec[0].x == CORDIC_GAIN && chain_vec[0].y == '0))
		else $error("bad CORDIC start values");

endmodule

`default_nettype wire

@@ test/v3ar_rotation_checker.sv @@
// ---------------------------------------------------------------------------
// v3ar_rotation_checker - scoreboard for the principal axis rotator
// Watches the request and result channels of the rotator. Each accepted request is
// run through a bit-exact model of the angle fold, CORDIC row and rounded,
// saturated pair rotation. Every result is matched against the oldest
// prediction. Mismatches and stray results are counted for the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module v3ar_rotation_checker #(
	parameter int ROT_STAGES = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [1:0]         axis,
	input  wire logic signed [31:0] vec_x,
	input  wire logic signed [31:0] vec_y,
	input  wire logic signed [31:0] vec_z,
	input  wire logic signed [31:0] angle_rad,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic signed [31:0] out_x,
	input  wire logic signed [31:0] out_y,
	input  wire logic signed [31:0] out_z,
	output int                      fail_count,
	output int                      pending
);
	import v3ar_pkg::*;

	// angle constants and gain, Q2.30
	localparam longint ANG_PI      = 64'sd3373259426;
	localparam longint ANG_TWO_PI  = 64'sd6746518852;
	localparam longint ANG_HALF_PI = 64'sd1686629713;
	localparam longint START_GAIN  = 64'sd652032874;
	localparam longint ROUND_HALF  = 64'sd536870912;
	localparam longint SAT_MAX     = 64'sd2147483647;
	localparam longint SAT_MIN     = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} rot_vec_t;

	rot_vec_t rotated_q [$];
	int       result_idx;

	// atan(2^-i) in Q2.30, truncated
	function automatic longint atan_q30(input int i);
		case (i)
			0: return 64'h3243F6A8;   1: return 64'h1DAC6705;
			2: return 64'h0FADBAFC;   3: return 64'h07F56EA6;
			4: return 64'h03FEAB76;   5: return 64'h01FFD55B;
			6: return 64'h00FFFAAA;   7: return 64'h007FFF55;
			8: return 64'h003FFFEA;   9: return 64'h001FFFFD;
			10: return 64'h000FFFFF;  11: return 64'h0007FFFF;
			12: return 64'h0003FFFF;  13: return 64'h0001FFFF;
			14: return 64'h0000FFFF;  15: return 64'h00007FFF;
			16: return 64'h00003FFF;  17: return 64'h00001FFF;
			18: return 64'h00000FFF;  19: return 64'h000007FF;
			20: return 64'h000003FF;  21: return 64'h000001FF;
			22: return 64'h000000FF;  23: return 64'h0000007F;
			24: return 64'h0000003F;  25: return 64'h0000001F;
			26: return 64'h0000000F;  27: return 64'h00000008;
			28: return 64'h00000004;  29: return 64'h00000002;
			30: return 64'h00000001;  default: return 64'h0;
		endcase
	endfunction

	// reduce the angle into [-pi, pi], fold it into [-pi/2, pi/2], run the CORDIC row, undo the fold
	function automatic void sin_cos_q30(input logic signed [31:0] ang_in,
			output longint cos_q, output longint sin_q);
		longint a;
		longint cx;
		longint cy;
		longint cz;
		longint xs;
		longint ys;
		bit     flip;
		a = longint'(ang_in) * 4;
		flip = 1'b0;
		while (a > ANG_PI)
			a -= ANG_TWO_PI;
		while (a < -ANG_PI)
			a += ANG_TWO_PI;
		if (a > ANG_HALF_PI) begin
			a -= ANG_PI;
			flip = 1'b1;
		end else if (a < -ANG_HALF_PI) begin
			a += ANG_PI;
			flip = 1'b1;
		end
		cx = START_GAIN;
		cy = 0;
		cz = a;
		for (int i = 0; i < ROT_STAGES && i < 32; i++) begin
			xs = cx >>> i;
			ys = cy >>> i;
			if (cz >= 0) begin
				cx -= ys;
				cy += xs;
				cz -= atan_q30(i);
			end else begin
				cx += ys;
				cy -= xs;
				cz += atan_q30(i);
			end
		end
		cos_q = flip ? -cx : cx;
		sin_q = flip ? -cy : cy;
	endfunction

	// round half up from Q18.46 product sum back to Q16.16, then clamp
	function automatic logic signed [31:0] round_sat(input longint acc);
		longint r;
		r = (acc + ROUND_HALF) >>> 30;
		if (r > SAT_MAX)
			r = SAT_MAX;
		if (r < SAT_MIN)
			r = SAT_MIN;
		return r[31:0];
	endfunction

	function automatic rot_vec_t rotate_vec(input logic [1:0] ax,
			input logic signed [31:0] vx, input logic signed [31:0] vy,
			input logic signed [31:0] vz, input logic signed [31:0] ang);
		rot_vec_t r;
		longint   c;
		longint   s;
		longint   p;
		longint   q;
		logic signed [31:0] pr;
		logic signed [31:0] qr;
		r.x = vx;
		r.y = vy;
		r.z = vz;
		if (ax != AXIS_NONE) begin
			sin_cos_q30(ang, c, s);
			case (ax)
				AXIS_X: begin
					p = vy;
					q = vz;
				end
				AXIS_Y: begin
					p = vx;
					q = vz;
				end
				default: begin
					p = vx;
					q = vy;
				end
			endcase
			pr = round_sat(p * c - q * s);
			qr = round_sat(p * s + q * c);
			case (ax)
				AXIS_X: begin
					r.y = pr;
					r.z = qr;
				end
				AXIS_Y: begin
					r.x = pr;
					r.z = qr;
				end
				default: begin
					r.x = pr;
					r.y = qr;
				end
			endcase
		end
		return r;
	endfunction

	task automatic cmp_component(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$display("%0t: result %0d %s mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
				$time, result_idx, name, want, want, got, got);
			fail_count++;
		end
	endtask

	// compare results first, then record the new request
	always @(posedge clk or negedge arst_n) begin
		rot_vec_t want;
		if (!arst_n) begin
			rotated_q.delete();
			fail_count = 0;
			pending = 0;
			result_idx = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (rotated_q.size() == 0) begin
					$display("%0t: result %0d with no request outstanding, got %0d %0d %0d",
						$time, result_idx, out_x, out_y, out_z);
					fail_count++;
				end else begin
					want = rotated_q.pop_front();
					cmp_component("out_x", want.x, out_x);
					cmp_component("out_y", want.y, out_y);
					cmp_component("out_z", want.z, out_z);
				end
				result_idx++;
			end
			if (in_valid && in_ready)
				rotated_q.push_back(rotate_vec(axis, vec_x, vec_y, vec_z, angle_rad));
			pending = rotated_q.size();
		end
	end

endmodule

@@ test/tb_vec3_axis_rotator_unit.sv @@
// ---------------------------------------------------------------------------
// tb_vec3_axis_rotator_unit - testbench of the principal axis rotator
// Directed requests at the field extremes, every axis code and the angle
// fold boundaries, then random bursts of requests against a receiver with
// its own stall pattern and one long hold-off that backs up the pipeline.
// Checking is done by v3ar_rotation_checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_vec3_axis_rotator_unit;
	import v3ar_pkg::*;

	localparam int ROT_STAGES = 24;
	localparam int N_RANDOM   = 1750;
	localparam int LIMIT_NS   = 2000000;
	// Q4.28 pi/2, rounded down; fold boundaries sit just above multiples of it
	localparam int Q28_HALF_PI = 421657428;
	localparam int Q28_PI      = 843314856;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         axis;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;
	logic signed [31:0] angle_rad;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	int                 fail_count;
	int                 pending;

	vec3_axis_rotator_unit #(
		.ROT_STAGES(ROT_STAGES)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.axis      (axis),
		.vec_x     (vec_x),
		.vec_y     (vec_y),
		.vec_z     (vec_z),
		.angle_rad (angle_rad),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z)
	);

	v3ar_rotation_checker #(
		.ROT_STAGES(ROT_STAGES)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.axis       (axis),
		.vec_x      (vec_x),
		.vec_y      (vec_y),
		.vec_z      (vec_z),
		.angle_rad  (angle_rad),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// offer one request and hold it until accepted
	task automatic send_req(input logic [1:0] ax, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z, input logic [31:0] ang);
		axis      <= ax;
		vec_x     <= x;
		vec_y     <= y;
		vec_z     <= z;
		angle_rad <= ang;
		in_valid  <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// component: full range, small, extreme or mid magnitude
	function automatic logic [31:0] rand_component();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 2097152) - 1048576;
			2: begin
				case ($urandom_range(0, 4))
					0: return 32'h7FFFFFFF;
					1: return 32'h80000000;
					2: return 32'h00000000;
					3: return 32'h00010000;
					default: return 32'hFFFFFFFF;
				endcase
			end
			default: return $signed($urandom) >>> $urandom_range(4, 14);
		endcase
	endfunction

	// angle: mostly full range, some hugging multiples of pi/2
	function automatic logic [31:0] rand_angle();
		int k;
		if ($urandom_range(0, 3) == 0) begin
			k = $urandom_range(0, 10);
			k = k - 5;
			return k * Q28_HALF_PI + $urandom_range(0, 8) - 4;
		end
		return $urandom;
	endfunction

	task automatic send_random_req();
		logic [1:0] ax;
		ax = ($urandom_range(0, 9) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
		send_req(ax, rand_component(), rand_component(), rand_component(), rand_angle());
	endtask

	// request stream
	initial begin
		int sent;
		int burst;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		axis      = AXIS_X;
		vec_x     = '0;
		vec_y     = '0;
		vec_z     = '0;
		angle_rad = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, each axis, unused axis code, fold edges, saturation
		send_req(AXIS_X, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h0);
		send_req(AXIS_Y, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		send_req(AXIS_Z, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
		send_req(AXIS_NONE, 32'h12345678, 32'h80000000, 32'h7FFFFFFF, 32'h10000000);
		send_req(AXIS_NONE, 32'hFFFFFFFF, 32'h0, 32'h00000001, 32'hFFFFFFFF);
		send_req(AXIS_X, 32'h00010000, 32'h00010000, 32'h0, Q28_HALF_PI);
		send_req(AXIS_X, 32'h00010000, 32'h00010000, 32'h0, Q28_HALF_PI + 1);
		send_req(AXIS_Y, 32'h00010000, 32'h0, 32'h00010000, -Q28_HALF_PI);
		send_req(AXIS_Y, 32'h00010000, 32'h0, 32'h00010000, -Q28_HALF_PI - 1);
		send_req(AXIS_Z, 32'h00010000, 32'h00020000, 32'h5, Q28_PI);
		send_req(AXIS_Z, 32'h00010000, 32'h00020000, 32'h5, Q28_PI + 1);
		send_req(AXIS_X, 32'h0, 32'hFFFF0000, 32'h00030000, -Q28_PI);
		send_req(AXIS_X, 32'h0, 32'hFFFF0000, 32'h00030000, -Q28_PI - 1);
		// pi/4: one output of the pair near sqrt(2) times full scale, must clamp
		send_req(AXIS_Z, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 210828714);
		send_req(AXIS_Z, 32'h80000000, 32'h80000000, 32'h0, -210828714);
		send_req(AXIS_Y, 32'h7FFFFFFF, 32'h1, 32'h80000000, 210828714);
		send_req(AXIS_X, 32'h1, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
		send_req(AXIS_Z, 32'hDEADBEEF, 32'h21524110, 32'h55555555, 5 * Q28_HALF_PI);
		send_req(AXIS_Y, 32'hAAAAAAAA, 32'h55555555, 32'h55555555, -5 * Q28_HALF_PI);
		send_req(AXIS_X, 32'h00008000, 32'hFFFF8000, 32'h00008000, 32'h1);
		send_req(AXIS_Z, 32'hFFFFFFFF, 32'h00000001, 32'h0, 32'hFFFFFFFF);

		// random bursts with gaps
		sent = 0;
		while (sent < N_RANDOM) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
				send_random_req();
				sent++;
			end
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8))
					@(posedge clk);
			end
		end
		in_valid <= 1'b0;

		// drain, then allow the pipeline depth for stray results
		while (pending != 0)
			@(posedge clk);
		repeat (ROT_STAGES + 10)
			@(posedge clk);
		if (fail_count == 0)
			$display("tb_vec3_axis_rotator_unit passed");
		else
			$display("tb_vec3_axis_rotator_unit failed");
		$finish;
	end

	// result side: randomly drawn stall modes, one long hold-off
	initial begin
		int cyc;
		int mode;
		out_ready = 1'b0;
		cyc = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			if (cyc >= 1200 && cyc < 1450) begin
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ~out_ready;
				endcase
			end
		end
	end

	// run limit
	initial begin
		#(LIMIT_NS);
		$display("tb_vec3_axis_rotator_unit failed");
		$finish;
	end

endmodule
